@@ rtl/gvh_pkg.sv @@
// Shared types and constants for the Gaussian visit heatmap.
// No dependencies; used by the interfaces, the RAM user and the top level.
package gvh_pkg;

  localparam int POS_W      = 28;
  localparam int CELL_W     = 7;
  localparam int WEIGHT_W   = 24;
  localparam int COUNT_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int GW         = 30;   // cell coordinate relative to window centre
  localparam int DW         = 48;   // signed distance in 1/16 units

  localparam logic [WEIGHT_W-1:0] ACC_MAX    = 24'hFF_FFFF;
  localparam logic [31:0]         DIST_CLAMP = 32'h8000_0000;
  localparam logic [31:0]         EXP_STEP_Q32 = 32'd4143190106;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_PITCH   = 3'd0,
    CFG_PITCH_RECIP  = 3'd1,
    CFG_CELL_RADIUS  = 3'd2,
    CFG_INFL_RAD_SQ  = 3'd3,
    CFG_EXP_SCALE    = 3'd4
  } cfg_reg_t;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_CLEAR  = 10'b00_0000_0010,
    ST_CENTRE = 10'b00_0000_0100,
    ST_BASE   = 10'b00_0000_1000,
    ST_START  = 10'b00_0001_0000,
    ST_WALK   = 10'b00_0010_0000,
    ST_DRAIN  = 10'b00_0100_0000,
    ST_READ   = 10'b00_1000_0000,
    ST_RDATA  = 10'b01_0000_0000,
    ST_FINISH = 10'b10_0000_0000
  } state_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [COUNT_W-1:0]  cells_updated;
    logic                out_of_window;
    logic                saturated;
  } result_t;

  // Entry k of the exp table: about round(4096 * 10^(-k/64)), by a rounded Q32 recurrence.
  // Evaluated at elaboration only.
  function automatic logic [WEIGHT_W-1:0] exp_entry(input int k);
    logic [95:0] v;
    logic [95:0] r;
    v = 96'h1_0000_0000;
    for (int i = 0; i < k; i++) begin
      v = ((v * {64'd0, EXP_STEP_Q32}) + 96'h8000_0000) >> 32;
    end
    r = (v + 96'h8_0000) >> 20;
    return r[WEIGHT_W-1:0];
  endfunction

endpackage

@@ rtl/gvh_if.sv @@
// Valid/ready channels of the heatmap: deposit/read items in, results out.
// Depends on gvh_pkg for field widths.
interface gvh_in_if
  import gvh_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [CELL_W-1:0] cell_col;
  logic signed [CELL_W-1:0] cell_row;

  modport source (output valid, action, pos_x, pos_y, cell_col, cell_row, input ready);
  modport sink   (input valid, action, pos_x, pos_y, cell_col, cell_row, output ready);
endinterface

interface gvh_out_if
  import gvh_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [WEIGHT_W-1:0] weight;
  logic [COUNT_W-1:0]  cells_updated;
  logic                out_of_window;
  logic                saturated;

  modport source (output valid, weight, cells_updated, out_of_window, saturated, input ready);
  modport sink   (input valid, weight, cells_updated, out_of_window, saturated, output ready);
endinterface

@@ rtl/gaussian_visit_heatmap.sv @@
// Gaussian visit heatmap top level: window of cell accumulators in one RAM.
// Depends on gvh_pkg, gvh_if (gvh_in_if, gvh_out_if) and gvh_ram.
//
//   port      dir   beat contents
//   in_chan   in    action, pos_x, pos_y, cell_col, cell_row
//   out_chan  out   weight, cells_updated, out_of_window, saturated
//   cfg_*     in    register write: enable, index, data (no handshake)
//
// After reset a clearing pass zeroes all WINDOW_COLS * WINDOW_ROWS RAM entries
// (16384 by default), one entry a cycle, with in_chan not ready. A read item
// passes ST_READ and ST_RDATA; a deposit with non-zero pitch walks (2r+1)^2
// cells, r the clamped cell radius, one RAM read-modify-write per cell in range.
// One item at a time; a finished result waits in the output register while
// the next item is taken, and holds the block only if a second one is ready.
module gaussian_visit_heatmap
  import gvh_pkg::*;
#(
  parameter int WINDOW_COLS     = 128,
  parameter int WINDOW_ROWS     = 128,
  parameter int MAX_CELL_RADIUS = 7,
  parameter int EXP_TABLE_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  gvh_in_if.sink                in_chan,
  gvh_out_if.source             out_chan,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CELLS = WINDOW_COLS * WINDOW_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CB    = $clog2(WINDOW_COLS);
  localparam int RB    = $clog2(WINDOW_ROWS);
  localparam int TW    = $clog2(EXP_TABLE_DEPTH);
  localparam int RADW  = $clog2(MAX_CELL_RADIUS + 1);
  localparam int CNTW  = $clog2(2 * MAX_CELL_RADIUS + 1);

  // ---------------- configuration registers ----------------
  logic [15:0] pitch_r;
  logic [23:0] recip_r;
  logic [2:0]  radius_r;
  logic [31:0] irsq_r;
  logic [31:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r  <= 16'd800;
      recip_r  <= 24'd20972;
      radius_r <= 3'd7;
      irsq_r   <= 32'd26528000;
      scale_r  <= 32'd10362;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_GRID_PITCH:  pitch_r  <= cfg_wdata[15:0];
        CFG_PITCH_RECIP: recip_r  <= cfg_wdata[23:0];
        CFG_CELL_RADIUS: radius_r <= cfg_wdata[2:0];
        CFG_INFL_RAD_SQ: irsq_r   <= cfg_wdata;
        CFG_EXP_SCALE:   scale_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- exp table ----------------
  logic [WEIGHT_W-1:0] exp_rom [EXP_TABLE_DEPTH];

  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_exp
    localparam logic [WEIGHT_W-1:0] EV = exp_entry(g);
    assign exp_rom[g] = EV;
  end

  // ---------------- window helpers ----------------
  function automatic logic win_ok(input logic signed [GW-1:0] c,
                                  input logic signed [GW-1:0] r);
    logic [GW-1:0] col;
    logic [GW-1:0] row;
    col = c + GW'(WINDOW_COLS / 2);
    row = r + GW'(WINDOW_ROWS / 2);
    return (col < GW'(WINDOW_COLS)) && (row < GW'(WINDOW_ROWS));
  endfunction

  function automatic logic [AW-1:0] win_idx(input logic signed [GW-1:0] c,
                                            input logic signed [GW-1:0] r);
    logic [GW-1:0] col;
    logic [GW-1:0] row;
    col = c + GW'(WINDOW_COLS / 2);
    row = r + GW'(WINDOW_ROWS / 2);
    return AW'(AW'(row[RB-1:0]) * AW'(WINDOW_COLS) + AW'(col[CB-1:0]));
  endfunction

  // ---------------- control and item registers ----------------
  state_t state_r, state_nxt;

  logic                     action_r;
  logic signed [POS_W-1:0]  px_r, py_r;
  logic signed [GW-1:0]     rc_r, rr_r;
  logic signed [GW-1:0]     cx_r, cy_r;
  logic signed [DW-1:0]     bx_r, by_r;
  logic [RADW-1:0]          rad_r;
  logic [AW-1:0]            clr_r;

  // walk generator
  logic signed [DW-1:0] dx_r, dy_r, dy0_r;
  logic signed [GW-1:0] gx_r, gy_r, gy0_r;
  logic [CNTW-1:0]      ox_r, oy_r;

  // per-cell pipeline
  logic              a_v, b_v, c_v, d_v, e_v;
  logic              a_in, b_in, c_in, d_in;
  logic [AW-1:0]     a_idx, b_idx, c_idx, d_idx, e_idx;
  logic [31:0]       a_ax, a_ay;
  logic [63:0]       b_sqx, b_sqy;
  logic [31:0]       c_d2;
  logic [31:0]       d_ti;
  logic [WEIGHT_W-1:0] e_w;

  logic [COUNT_W-1:0] upd_r;
  logic               oow_r, sat_r;

  result_t res_r, res_nxt;
  logic    res_load;
  logic    out_valid_r;
  result_t out_r;

  // ---------------- RAM ----------------
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [WEIGHT_W-1:0] ram_wdata, ram_rdata;

  gvh_ram #(.WIDTH(WEIGHT_W), .DEPTH(CELLS)) u_cells (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // ---------------- combinational datapath ----------------
  logic                 in_acc;
  logic                 walk_last;
  logic                 pipe_empty;
  logic signed [52:0]   mx, my;
  logic [RADW+15:0]     rp;
  logic [DW-1:0]        mag_x, mag_y;
  logic [63:0]          d2;
  logic [63:0]          tprod;
  logic [TW-1:0]        ti;
  logic [WEIGHT_W:0]    sum;
  logic                 sum_sat;
  logic                 rd_in;

  assign in_acc     = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == ST_IDLE);
  assign walk_last  = (ox_r == CNTW'(2 * rad_r)) && (oy_r == CNTW'(2 * rad_r));
  assign pipe_empty = !(a_v || b_v || c_v || d_v || e_v);

  assign mx    = px_r * $signed({1'b0, recip_r}) + 53'sd8388608;
  assign my    = py_r * $signed({1'b0, recip_r}) + 53'sd8388608;
  assign rp    = rad_r * pitch_r;
  assign mag_x = dx_r[DW-1] ? DW'(-dx_r) : DW'(dx_r);
  assign mag_y = dy_r[DW-1] ? DW'(-dy_r) : DW'(dy_r);
  assign d2    = b_sqx + b_sqy;
  assign tprod = {32'd0, c_d2} * {32'd0, scale_r};
  assign ti    = (d_ti > 32'(EXP_TABLE_DEPTH - 1)) ? TW'(EXP_TABLE_DEPTH - 1) : d_ti[TW-1:0];
  assign sum   = {1'b0, ram_rdata} + {1'b0, e_w};
  assign sum_sat = (sum >= {1'b0, ACC_MAX});
  assign rd_in = win_ok(rc_r, rr_r);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = e_idx;
    ram_wdata = sum_sat ? ACC_MAX : sum[WEIGHT_W-1:0];
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else if (e_v) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    ram_re    = d_v && d_in;
    ram_raddr = d_idx;
    if (state_r == ST_READ) begin
      ram_re    = rd_in;
      ram_raddr = win_idx(rc_r, rr_r);
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    res_load  = 1'b0;
    case (state_r)
      ST_CLEAR: if (clr_r == AW'(CELLS - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          if (in_chan.action) begin
            state_nxt = ST_READ;
          end else if (pitch_r == '0) begin
            res_nxt   = '0;
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_CENTRE;
          end
        end
      end
      ST_READ:   state_nxt = ST_RDATA;
      ST_RDATA: begin
        res_nxt.cells_updated = '0;
        res_nxt.out_of_window = !rd_in;
        res_nxt.weight        = rd_in ? ram_rdata : '0;
        res_nxt.saturated     = rd_in && (ram_rdata == ACC_MAX);
        state_nxt = ST_FINISH;
      end
      ST_CENTRE: state_nxt = ST_BASE;
      ST_BASE:   state_nxt = ST_START;
      ST_START:  state_nxt = ST_WALK;
      ST_WALK:   if (walk_last) state_nxt = ST_DRAIN;
      ST_DRAIN: begin
        if (pipe_empty) begin
          res_nxt.weight        = '0;
          res_nxt.cells_updated = upd_r;
          res_nxt.out_of_window = oow_r;
          res_nxt.saturated     = sat_r;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_r || out_chan.ready) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      e_v <= 1'b0;
      upd_r <= '0;
      oow_r <= 1'b0;
      sat_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + AW'(1);

      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      a_v <= (state_r == ST_WALK);
      b_v <= a_v;
      c_v <= b_v && (d2 <= {32'd0, irsq_r});
      d_v <= c_v;
      e_v <= d_v && d_in;

      if (state_r == ST_START) begin
        upd_r <= '0;
        oow_r <= 1'b0;
        sat_r <= 1'b0;
      end else begin
        if (d_v && !d_in) oow_r <= 1'b1;
        if (e_v) begin
          upd_r <= upd_r + COUNT_W'(1);
          if (sum_sat) sat_r <= 1'b1;
        end
      end
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (res_load) out_r <= res_r;

    if (in_acc) begin
      action_r <= in_chan.action;
      px_r     <= in_chan.pos_x;
      py_r     <= in_chan.pos_y;
      rc_r     <= GW'(in_chan.cell_col);
      rr_r     <= GW'(in_chan.cell_row);
    end

    if (state_r == ST_CENTRE) begin
      cx_r  <= GW'(mx >>> 24);
      cy_r  <= GW'(my >>> 24);
      rad_r <= (32'(radius_r) > MAX_CELL_RADIUS) ? RADW'(MAX_CELL_RADIUS)
                                                 : RADW'(radius_r);
    end

    if (state_r == ST_BASE) begin
      bx_r <= DW'(cx_r * $signed({1'b0, pitch_r}));
      by_r <= DW'(cy_r * $signed({1'b0, pitch_r}));
    end

    if (state_r == ST_START) begin
      dx_r  <= bx_r - DW'(rp) - DW'(px_r);
      dy_r  <= by_r - DW'(rp) - DW'(py_r);
      dy0_r <= by_r - DW'(rp) - DW'(py_r);
      gx_r  <= cx_r - GW'(rad_r);
      gy_r  <= cy_r - GW'(rad_r);
      gy0_r <= cy_r - GW'(rad_r);
      ox_r  <= '0;
      oy_r  <= '0;
    end else if (state_r == ST_WALK) begin
      // rows inner, columns outer
      if (oy_r == CNTW'(2 * rad_r)) begin
        oy_r <= '0;
        dy_r <= dy0_r;
        gy_r <= gy0_r;
        ox_r <= ox_r + CNTW'(1);
        dx_r <= dx_r + DW'(pitch_r);
        gx_r <= gx_r + GW'(1);
      end else begin
        oy_r <= oy_r + CNTW'(1);
        dy_r <= dy_r + DW'(pitch_r);
        gy_r <= gy_r + GW'(1);
      end
    end

    // stage A: clamp distances, window check
    a_ax  <= (mag_x > DW'(DIST_CLAMP)) ? DIST_CLAMP : mag_x[31:0];
    a_ay  <= (mag_y > DW'(DIST_CLAMP)) ? DIST_CLAMP : mag_y[31:0];
    a_in  <= win_ok(gx_r, gy_r);
    a_idx <= win_idx(gx_r, gy_r);
    // stage B: squares
    b_sqx <= {32'd0, a_ax} * {32'd0, a_ax};
    b_sqy <= {32'd0, a_ay} * {32'd0, a_ay};
    b_in  <= a_in;
    b_idx <= a_idx;
    // stage C: sum and cutoff
    c_d2  <= d2[31:0];
    c_in  <= b_in;
    c_idx <= b_idx;
    // stage D: scale to table index
    d_ti  <= tprod[63:32];
    d_in  <= c_in;
    d_idx <= c_idx;
    // stage E: table lookup while the RAM read is in flight
    e_w   <= exp_rom[ti];
    e_idx <= d_idx;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.weight        = out_r.weight;
  assign out_chan.cells_updated = out_r.cells_updated;
  assign out_chan.out_of_window = out_r.out_of_window;
  assign out_chan.saturated     = out_r.saturated;

  // ---------------- assertions ----------------
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_READ || state_r == ST_CENTRE || state_r == ST_FINISH))
    else $error("item taken outside idle");

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> pipe_empty)
    else $error("cell pipeline busy while idle");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLEAR || state_r == ST_WALK || state_r == ST_DRAIN))
    else $error("RAM written outside clear or walk");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result raised without finish");

  a_read_action: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> action_r)
    else $error("read path entered for a deposit");

endmodule

@@ rtl/gvh_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module gvh_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
